[rtl/core/mf3_pkg.sv]
// Shared types and constants of the 3x3 RGB median filter.
// No dependencies; compiled first.
package mf3_pkg;

  // Window geometry and the rank of the median among nine samples
  localparam int WIN_DIM   = 3;
  localparam int WIN_CELLS = 9;
  localparam int MID_RANK  = 4;

  // Configuration register and port widths, minimum and reset values
  localparam int CFG_W_WIDTH  = 11;
  localparam int CFG_H_WIDTH  = 13;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int CFG_MIN      = 3;
  localparam logic [CFG_W_WIDTH-1:0] WIDTH_RST  = 11'd256;
  localparam logic [CFG_H_WIDTH-1:0] HEIGHT_RST = 13'd256;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] pix_t;

  // Control carried alongside an item down the pipe
  typedef struct packed {
    logic prod;
    logic border;
    logic last;
  } pipe_ctl_t;

endpackage

[rtl/core/mf3_if.sv]
// Valid/ready channel interfaces for pixel items and result items.
// Depends on mf3_pkg.
interface mf3_pix_if;
  import mf3_pkg::*;
  logic  valid;
  logic  ready;
  logic  cmd;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface mf3_res_if;
  import mf3_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic  frame_last;
  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

[rtl/core/median_filter_3x3_rgb.sv]
// Streaming 3x3 median filter for 24-bit RGB pixels in raster order. The block
// takes one item per clock while ready is high; ready drops only while the
// output register holds a result not yet taken. Each pixel costs one read and
// one write of each line store, which sets the one-item-per-cycle figure. A
// result appears for every pixel from the (width+2)-th of a frame on, for the
// pixel width+1 items earlier; border pixels pass unchanged. After the last
// pixel, width+1 drain items release the rest, the final one marked frame_last.
// Pixels after the last and drains during a frame are taken and dropped.
// Registers: image_width at 0x0, image_height at 0x4, clamped to [3, MAX]; write
// them only while the block is idle.
module median_filter_3x3_rgb import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  mf3_pix_if.sink           in_ch,
  mf3_res_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_W_WIDTH-1:0] width_r;
  logic [CFG_H_WIDTH-1:0] height_r;
  logic [CFG_W_WIDTH-1:0] wr_width;
  logic [CFG_H_WIDTH-1:0] wr_height;
  logic                   cfg_wr;
  cfg_reg_e               cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_e'(cfg_paddr[CFG_AW-1]);

  // Clamp written values into range
  always_comb begin
    wr_width  = cfg_pwdata[CFG_W_WIDTH-1:0];
    wr_height = cfg_pwdata[CFG_H_WIDTH-1:0];
    if (32'(wr_width) < 32'(CFG_MIN)) begin
      wr_width = CFG_W_WIDTH'(CFG_MIN);
    end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
      wr_width = CFG_W_WIDTH'(MAX_WIDTH);
    end
    if (32'(wr_height) < 32'(CFG_MIN)) begin
      wr_height = CFG_H_WIDTH'(CFG_MIN);
    end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
      wr_height = CFG_H_WIDTH'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_r  <= wr_width;
        REG_HEIGHT: height_r <= wr_height;
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Frame position counters and input-complete flag
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic             done_r, done_nxt;
  logic             out_valid_r;
  logic             advance, take_item, is_drain, enter, prod;
  logic             in_col_end, in_row_end, out_col_end, out_row_end;
  pipe_ctl_t        ctl_nxt;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign take_item   = in_ch.valid && advance;
  assign is_drain    = (cmd_e'(in_ch.cmd) == CMD_DRAIN);

  assign in_col_end  = 32'(in_col_r)  >= 32'(width_r)  - 32'd1;
  assign in_row_end  = 32'(in_row_r)  >= 32'(height_r) - 32'd1;
  assign out_col_end = 32'(out_col_r) >= 32'(width_r)  - 32'd1;
  assign out_row_end = 32'(out_row_r) >= 32'(height_r) - 32'd1;

  // Decide what an item does and step the counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    done_nxt    = done_r;
    enter       = 1'b0;
    prod        = 1'b0;
    ctl_nxt.border = (out_row_r == '0) || (out_col_r == '0) || out_row_end || out_col_end;
    ctl_nxt.last   = out_row_end && out_col_end;
    if (take_item) begin
      if (!is_drain) begin
        if (!done_r) begin
          enter = 1'b1;
          prod  = (32'(in_row_r) >= 32'd2) || ((32'(in_row_r) == 32'd1) && (in_col_r != '0));
          if (in_col_end) begin
            in_col_nxt = '0;
            if (in_row_end) begin
              in_row_nxt = '0;
              done_nxt   = 1'b1;
            end else begin
              in_row_nxt = in_row_r + 1'b1;
            end
          end else begin
            in_col_nxt = in_col_r + 1'b1;
          end
        end
      end else if (done_r) begin
        enter = 1'b1;
        prod  = 1'b1;
        if (ctl_nxt.last) begin
          done_nxt = 1'b0;
        end
      end
      if (prod) begin
        if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_end ? '0 : out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
    ctl_nxt.prod = prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      done_r    <= done_nxt;
    end
  end

  // Stage 1: line store read in flight
  logic             s1_valid_r, s1_drain_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_px_r;
  pipe_ctl_t        s1_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_drain_r <= is_drain;
      s1_col_r   <= in_col_r;
      s1_px_r    <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
      s1_ctl_r   <= ctl_nxt;
    end
  end

  // Line stores: read at the incoming column, write back one stage later
  logic ln_re, ln_we;
  pix_t up_rd, mid_rd;

  assign ln_re = advance && enter && !is_drain;
  assign ln_we = advance && s1_valid_r && !s1_drain_r;

  mf3_ram #(.DATA_W(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ln_we),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (ln_re),
    .raddr (in_col_r),
    .rdata (up_rd)
  );

  mf3_ram #(.DATA_W(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ln_we),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (ln_re),
    .raddr (in_col_r),
    .rdata (mid_rd)
  );

  // Window: three rows of three cells, new column enters at the right
  logic win_shift;
  pix_t src     [WIN_DIM];
  pix_t win_q   [WIN_CELLS];
  pix_t win_d   [WIN_CELLS];

  assign win_shift = advance && s1_valid_r;
  assign src[0]    = s1_drain_r ? '0 : up_rd;
  assign src[1]    = s1_drain_r ? '0 : mid_rd;
  assign src[2]    = s1_drain_r ? '0 : s1_px_r;

  for (genvar r = 0; r < WIN_DIM; r++) begin : g_row
    for (genvar c = 0; c < WIN_DIM; c++) begin : g_col
      if (c == WIN_DIM - 1) begin : g_edge
        assign win_d[r*WIN_DIM+c] = src[r];
      end else begin : g_inner
        assign win_d[r*WIN_DIM+c] = win_q[r*WIN_DIM+c+1];
      end
      mf3_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (win_shift),
        .d_i   (win_d[r*WIN_DIM+c]),
        .q_o   (win_q[r*WIN_DIM+c])
      );
    end
  end

  // Stage 2: window holds the item's neighbourhood
  logic      s2_valid_r;
  pipe_ctl_t s2_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r && s1_ctl_r.prod;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // Stage 3: per-channel rank compares
  chan_t smp_r [WIN_CELLS];
  chan_t smp_g [WIN_CELLS];
  chan_t smp_b [WIN_CELLS];
  chan_t med_r, med_g, med_b, ctr_r, ctr_g, ctr_b;

  always_comb begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      smp_r[i] = win_q[i][23:16];
      smp_g[i] = win_q[i][15:8];
      smp_b[i] = win_q[i][7:0];
    end
  end

  mf3_med u_med_r (.clk(clk), .en(advance), .smp_i(smp_r), .med_o(med_r), .ctr_o(ctr_r));
  mf3_med u_med_g (.clk(clk), .en(advance), .smp_i(smp_g), .med_o(med_g), .ctr_o(ctr_g));
  mf3_med u_med_b (.clk(clk), .en(advance), .smp_i(smp_b), .med_o(med_b), .ctr_o(ctr_b));

  logic      s3_valid_r;
  pipe_ctl_t s3_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  // Output register: median, or centre pixel on the border
  chan_t out_red_r, out_green_r, out_blue_r;
  logic  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_red_r   <= s3_ctl_r.border ? ctr_r : med_r;
      out_green_r <= s3_ctl_r.border ? ctr_g : med_g;
      out_blue_r  <= s3_ctl_r.border ? ctr_b : med_b;
      out_last_r  <= s3_ctl_r.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = out_red_r;
  assign out_ch.green_out  = out_green_r;
  assign out_ch.blue_out   = out_blue_r;
  assign out_ch.frame_last = out_last_r;

  // A line store entry is never read in the cycle it is written
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ln_re && ln_we) |-> (in_col_r != s1_col_r))
    else $error("line store read and write at the same column");

  // The frame completes exactly as the input position wraps to the origin
  a_done_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> (in_row_r == '0 && in_col_r == '0))
    else $error("input complete without wrap of the input position");

  // The complete flag clears only as the output position wraps to the origin
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(done_r) |-> (out_row_r == '0 && out_col_r == '0))
    else $error("input complete cleared away from the frame end");

endmodule

[rtl/core/mf3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mf3_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port, and read port that holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/mf3_cell.sv]
// One window cell: holds a pixel and takes the pixel at its input on shift.
// Depends on mf3_pkg.
module mf3_cell import mf3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic shift,
  input  pix_t d_i,
  output pix_t q_o
);

  pix_t pix_r;

  // Advance the row by one place on shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift) begin
      pix_r <= d_i;
    end
  end

  assign q_o = pix_r;

endmodule

[rtl/core/mf3_med.sv]
// Median of nine 8-bit samples: registered rank compares, then rank select.
// Depends on mf3_pkg.
module mf3_med import mf3_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  chan_t smp_i [WIN_CELLS],
  output chan_t med_o,
  output chan_t ctr_o
);

  chan_t                smp_r   [WIN_CELLS];
  logic [WIN_CELLS-1:0] pre_r   [WIN_CELLS];
  logic [WIN_CELLS-1:0] pre_nxt [WIN_CELLS];

  // Sample j precedes sample i when smaller, ties broken by position
  always_comb begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      for (int j = 0; j < WIN_CELLS; j++) begin
        if (j < i) begin
          pre_nxt[i][j] = (smp_i[j] <= smp_i[i]);
        end else if (j > i) begin
          pre_nxt[i][j] = (smp_i[j] < smp_i[i]);
        end else begin
          pre_nxt[i][j] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp_r <= smp_i;
      pre_r <= pre_nxt;
    end
  end

  // Pick the one sample with exactly four predecessors
  always_comb begin
    med_o = '0;
    for (int i = 0; i < WIN_CELLS; i++) begin
      if ($countones(pre_r[i]) == MID_RANK) begin
        med_o = med_o | smp_r[i];
      end
    end
  end

  assign ctr_o = smp_r[MID_RANK];

endmodule

[verif/testbench.sv]
// Self-checking testbench for the streaming 3x3 RGB median filter.
// Depends on mf3_pkg, the mf3_pix_if / mf3_res_if interfaces and the block.
`timescale 1ns / 100ps

module testbench;
  import mf3_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } filt_res_t;

  typedef struct {
    cmd_e  cmd;
    pix_t  px;
    logic  chk;
    filt_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  mf3_pix_if pix_ch ();
  mf3_res_if res_ch ();

  median_filter_3x3_rgb u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pix_ch.sink), .out_ch(res_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  // Predictor state
  pix_t upper_row [1024];
  pix_t middle_row [1024];
  pix_t win [9];
  int unsigned in_col, in_row, out_col, out_row;
  bit frame_in_done;
  int unsigned img_w, img_h;

  filt_res_t expected_q[$];
  int errors = 0;
  int sent_items = 0;
  bit hold_off = 1'b0;

  function automatic chan_t median9(int sh);
    chan_t v [9];
    chan_t t;
    for (int i = 0; i < 9; i++) v[i] = chan_t'(win[i] >> sh);
    for (int i = 1; i < 9; i++)
      for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t = v[j]; v[j] = v[j-1]; v[j-1] = t;
      end
    return v[MID_RANK];
  endfunction

  function automatic void shift_window(pix_t t, pix_t m, pix_t b);
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = t; win[5] = m; win[8] = b;
  endfunction

  function automatic filt_res_t filter_centre();
    filt_res_t r;
    pix_t c = win[4];
    bit edge_px = out_row == 0 || out_col == 0 || out_row >= img_h - 1 ||
                  out_col >= img_w - 1;
    r.last = out_row >= img_h - 1 && out_col >= img_w - 1;
    if (edge_px) begin
      r.red = c[23:16]; r.green = c[15:8]; r.blue = c[7:0];
    end else begin
      r.red = median9(16); r.green = median9(8); r.blue = median9(0);
    end
    if (out_col >= img_w - 1) begin
      out_col = 0;
      out_row = (out_row >= img_h - 1) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted item; returns 1 with a result
  function automatic bit predict_filter(cmd_e cmd, pix_t px, output filt_res_t r);
    pix_t t, m;
    bit prod;
    r = '0;
    if (cmd == CMD_PIXEL) begin
      if (frame_in_done) return 0;
      t = upper_row[in_col]; m = middle_row[in_col];
      upper_row[in_col] = m; middle_row[in_col] = px;
      shift_window(t, m, px);
      prod = in_row >= 2 || (in_row == 1 && in_col >= 1);
      if (in_col >= img_w - 1) begin
        in_col = 0;
        if (in_row >= img_h - 1) begin
          in_row = 0; frame_in_done = 1;
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
      if (!prod) return 0;
      r = filter_centre();
      return 1;
    end
    if (!frame_in_done) return 0;
    shift_window('0, '0, '0);
    r = filter_centre();
    if (r.last) frame_in_done = 0;
    return 1;
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    return v < CFG_MIN ? CFG_MIN : (v > hi ? hi : v);
  endfunction

  // APB write: setup then access, register updates on the access edge
  task automatic cfg_write(cfg_reg_e idx, int unsigned val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= CFG_AW'(idx) << 2; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == REG_WIDTH) img_w = clamp(val & 'h7FF, 1024);
    else img_h = clamp(val & 'h1FFF, 4096);
  endtask

  // Send one item at the falling edge, hold until accepted
  task automatic send_item(cmd_e cmd, pix_t px, bit chk, filt_res_t want);
    filt_res_t r;
    pix_ch.valid <= 1; pix_ch.cmd <= cmd;
    pix_ch.red_in <= px[23:16]; pix_ch.green_in <= px[15:8]; pix_ch.blue_in <= px[7:0];
    do @(posedge clk); while (!pix_ch.ready);
    sent_items++;
    if (predict_filter(cmd, px, r)) begin
      if (chk && r != want) begin
        errors++;
        if (errors <= 10) $display("predictor/table disagree: %h vs %h", r, want);
      end
      expected_q.insert(expected_q.size(), r);
    end
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    pix_ch.valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_empty();
    pix_ch.valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Send a whole frame plus its drain, in bursts
  task automatic run_frame(int unsigned w, int unsigned h, int mode);
    int burst = 0;
    pix_t px;
    for (int k = 0; k < w * h + w + 1; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
      burst--;
      case (mode)
        0: px = pix_t'($urandom());
        1: px = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        default: px = {3{8'($urandom_range(100, 140))}};
      endcase
      // sprinkle noise items that the block drops
      if ($urandom_range(0, 40) == 0)
        send_item(k < w * h ? CMD_DRAIN : CMD_PIXEL, pix_t'($urandom()), 0, '0);
      send_item(k < w * h ? CMD_PIXEL : CMD_DRAIN, px, 0, '0);
    end
  endtask

  stim_row_t dir_tab [$];

  // Append one row to the directed table
  function automatic void queue_row(cmd_e c, pix_t px, logic chk, filt_res_t res);
    stim_row_t row;
    row.cmd = c; row.px = px; row.chk = chk; row.res = res;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // Receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) res_ch.ready <= 0;
    else res_ch.ready <= !hold_off && ($urandom_range(0, 7) > 2 || $urandom_range(0, 1));
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    filt_res_t got, want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.red_out, res_ch.green_out, res_ch.blue_out, res_ch.frame_last};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    pix_ch.valid = 0; pix_ch.cmd = CMD_PIXEL;
    pix_ch.red_in = 0; pix_ch.green_in = 0; pix_ch.blue_in = 0;
    res_ch.ready = 0;
    foreach (win[i]) win[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_in_done = 0;
    img_w = 256; img_h = 256;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: 3x3 frame with extremes; only the centre is filtered
    cfg_write(REG_WIDTH, 0);       // saturates to 3
    cfg_write(REG_HEIGHT, 1);      // saturates to 3
    queue_row(CMD_DRAIN, 24'h123456, 0, '0); // drain mid-frame: dropped
    for (int i = 0; i < 9; i++)
      queue_row(CMD_PIXEL, i[0] ? 24'hFFFFFF : 24'h000000, 0, '0);
    queue_row(CMD_PIXEL, 24'hABCDEF, 0, '0); // after last pixel: dropped
    // Last result is the bottom-right pixel (index 8, black) with frame_last
    for (int i = 0; i < 4; i++)
      queue_row(CMD_DRAIN, 24'h0, i == 3, '{8'h00, 8'h00, 8'h00, 1'b1});
    // Row 1 col 1 of the table frame is 0x000000 (index 4 even) -> median of
    // five zeros, four ones = 0; checked by the predictor.
    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].px, dir_tab[i].chk, dir_tab[i].res);
    wait_empty();

    // Long receiver hold-off while items keep coming
    cfg_write(REG_WIDTH, 5);
    cfg_write(REG_HEIGHT, 4);
    hold_off = 1;
    fork
      begin repeat (300) @(negedge clk); hold_off = 0; end
      run_frame(5, 4, 0);
    join
    wait_empty();

    // Random frames over several sizes, clamping extremes included
    cfg_write(REG_WIDTH, 16'hFFFF); // clamps to 1024
    cfg_write(REG_WIDTH, 200);
    cfg_write(REG_HEIGHT, 3);
    run_frame(200, 3, 0);
    wait_empty();
    cfg_write(REG_WIDTH, 3);
    cfg_write(REG_HEIGHT, 16'hFFFF); // clamps to 4096 via masked 0x1FFF
    cfg_write(REG_HEIGHT, 40);
    run_frame(3, 40, 1);
    wait_empty();
    while (sent_items < 1400) begin
      int unsigned w, h;
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 10);
      cfg_write(REG_WIDTH, w);
      cfg_write(REG_HEIGHT, h);
      run_frame(w, h, $urandom_range(0, 2));
      wait_empty();
    end

    repeat (20) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
